@@ design/ptmt_pkg.sv @@
// Package for the page table map and translate unit.
// Holds function and status codes, the control state type and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package ptmt_pkg;

    localparam int DEFAULT_VIRT_PAGES = 1024;
    // page counter width: holds any page index up to 2^20 and the count 2^20
    localparam int CW                 = 21;
    localparam int PAGE_SHIFT         = 12;
    localparam logic [31:0] FRAME_MASK = 32'hfffff000;
    localparam logic [31:0] PAGE_STEP  = 32'h00001000;

    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 64;

    localparam logic [2:0] FN_MAP       = 3'd0;
    localparam logic [2:0] FN_MAP_RANGE = 3'd1;
    localparam logic [2:0] FN_MAP_REGION = 3'd2;
    localparam logic [2:0] FN_TRANSLATE = 3'd3;
    localparam logic [2:0] FN_READ      = 3'd4;
    localparam logic [2:0] FN_FILL      = 3'd5;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_INVALID = 2'd1;
    localparam logic [1:0] STS_RANGE   = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_RUN,
        S_RDATA,
        S_DONE
    } state_t;

    typedef struct packed {
        logic          we;
        logic          re;
        logic [CW-1:0] waddr;
        logic [CW-1:0] raddr;
        logic [31:0]   wdata;
    } mem_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] phys_out;
        logic [31:0] entry_out;
    } result_t;

endpackage

@@ design/ptmt_mem.sv @@
// Page entry memory: one write port, one read port, registered read data.
// Depends on ptmt_pkg for the request struct.
`timescale 1ns / 1ps

module ptmt_mem #(
    parameter int DEPTH = ptmt_pkg::DEFAULT_VIRT_PAGES
) (
    input  logic              clk,
    input  ptmt_pkg::mem_req_t req,
    output logic [31:0]       rdata
);
    import ptmt_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [31:0] mem_array [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_array[req.waddr[AW-1:0]] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem_array[req.raddr[AW-1:0]];
        end
    end

endmodule

@@ design/ptmt_ctrl.sv @@
// Operation sequencer: decodes an item, steps page writes one a cycle,
// issues table reads and forms the result. Depends on ptmt_pkg.
`timescale 1ns / 1ps

module ptmt_ctrl #(
    parameter int VIRT_PAGES = ptmt_pkg::DEFAULT_VIRT_PAGES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          in_func,
    input  logic [31:0]         in_virt,
    input  logic [31:0]         in_phys,
    input  logic [31:0]         in_pend,
    input  logic [10:0]         in_count,
    input  logic [7:0]          in_flags,
    output ptmt_pkg::mem_req_t  mem_req,
    input  logic [31:0]         mem_rdata,
    output logic                res_valid,
    input  logic                res_ready,
    output ptmt_pkg::result_t   res
);
    import ptmt_pkg::*;

    localparam logic [CW-1:0] PAGES_C = CW'(VIRT_PAGES);

    state_t      state_reg, state_next;
    logic [2:0]  func_reg, func_next;
    logic [31:0] virt_reg, virt_next;
    logic [31:0] phys_reg, phys_next;
    logic [31:0] pend_reg, pend_next;
    logic [10:0] count_reg, count_next;
    logic [7:0]  flags_reg, flags_next;
    logic [CW-1:0] page_reg, page_next;
    logic [CW-1:0] remain_reg, remain_next;
    logic [31:0] pcur_reg, pcur_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] entry_reg, entry_next;

    logic [CW-1:0] vpage;
    logic          virt_ok;
    logic          vpage_in;
    logic [31:0]   region_diff;
    logic          region_ok;
    logic          run_end;
    logic          run_over;
    logic          decode_run;
    logic          decode_read;

    assign vpage       = {1'b0, virt_reg[31:PAGE_SHIFT]};
    assign virt_ok     = (virt_reg[PAGE_SHIFT-1:0] == '0);
    assign vpage_in    = (vpage < PAGES_C);
    assign region_diff = pend_reg - phys_reg;
    assign region_ok   = virt_ok && (phys_reg[PAGE_SHIFT-1:0] == '0)
                         && (pend_reg[PAGE_SHIFT-1:0] == '0) && (pend_reg >= phys_reg);
    assign run_end     = (remain_reg == '0);
    assign run_over    = (page_reg >= PAGES_C);

    always_comb
    begin
        decode_run  = 1'b0;
        decode_read = 1'b0;
        case (func_reg)
            FN_MAP, FN_MAP_RANGE: decode_run  = virt_ok;
            FN_MAP_REGION:        decode_run  = region_ok;
            FN_TRANSLATE, FN_READ: decode_read = vpage_in;
            FN_FILL:              decode_run  = 1'b1;
            default:              decode_run  = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (run_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (decode_run)
                begin
                    state_next = S_RUN;
                end
                else if (decode_read)
                begin
                    state_next = S_RDATA;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RUN:
            begin
                if (run_end || run_over)
                begin
                    state_next = S_DONE;
                end
            end
            S_RDATA:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        func_next   = func_reg;
        virt_next   = virt_reg;
        phys_next   = phys_reg;
        pend_next   = pend_reg;
        count_next  = count_reg;
        flags_next  = flags_reg;
        page_next   = page_reg;
        remain_next = remain_reg;
        pcur_next   = pcur_reg;
        status_next = status_reg;
        entry_next  = entry_reg;
        if (state_reg == S_IDLE && in_valid)
        begin
            func_next  = in_func;
            virt_next  = in_virt;
            phys_next  = in_phys;
            pend_next  = in_pend;
            count_next = in_count;
            flags_next = in_flags;
        end
        if (state_reg == S_DECODE)
        begin
            entry_next  = '0;
            status_next = STS_OK;
            page_next   = vpage;
            pcur_next   = phys_reg;
            case (func_reg)
                FN_MAP:
                begin
                    remain_next = CW'(1);
                    if (!virt_ok)
                    begin
                        status_next = STS_INVALID;
                    end
                end
                FN_MAP_RANGE:
                begin
                    remain_next = CW'(count_reg);
                    if (!virt_ok)
                    begin
                        status_next = STS_INVALID;
                    end
                end
                FN_MAP_REGION:
                begin
                    remain_next = {1'b0, region_diff[31:PAGE_SHIFT]};
                    if (!region_ok)
                    begin
                        status_next = STS_INVALID;
                    end
                end
                FN_TRANSLATE, FN_READ:
                begin
                    if (!vpage_in)
                    begin
                        status_next = STS_RANGE;
                    end
                end
                FN_FILL:
                begin
                    page_next   = '0;
                    pcur_next   = '0;
                    remain_next = PAGES_C;
                end
                default:
                begin
                    status_next = STS_INVALID;
                end
            endcase
        end
        // one page per cycle; reset init runs the same walk as a fill
        if ((state_reg == S_RUN || state_reg == S_INIT) && !run_end && !run_over)
        begin
            page_next   = page_reg + CW'(1);
            remain_next = remain_reg - CW'(1);
            pcur_next   = pcur_reg + PAGE_STEP;
        end
        if (state_reg == S_RUN && !run_end && run_over)
        begin
            status_next = STS_RANGE;
        end
        if (state_reg == S_RDATA)
        begin
            entry_next = mem_rdata;
        end
    end

    // outputs
    always_comb
    begin
        in_ready      = (state_reg == S_IDLE);
        mem_req.we    = (state_reg == S_RUN || state_reg == S_INIT) && !run_end && !run_over;
        mem_req.waddr = page_reg;
        mem_req.wdata = pcur_reg | {24'b0, flags_reg};
        mem_req.re    = (state_reg == S_DECODE) && decode_read;
        mem_req.raddr = vpage;
        res_valid     = (state_reg == S_DONE);
        res.status    = status_reg;
        res.entry_out = entry_reg;
        res.phys_out  = '0;
        if (func_reg == FN_TRANSLATE && status_reg == STS_OK)
        begin
            res.phys_out = (entry_reg & FRAME_MASK) + {20'b0, virt_reg[PAGE_SHIFT-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            page_reg   <= '0;
            remain_reg <= PAGES_C;
            pcur_reg   <= '0;
            flags_reg  <= '0;
            func_reg   <= FN_MAP;
            status_reg <= STS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            page_reg   <= page_next;
            remain_reg <= remain_next;
            pcur_reg   <= pcur_next;
            flags_reg  <= flags_next;
            func_reg   <= func_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        virt_reg  <= virt_next;
        phys_reg  <= phys_next;
        pend_reg  <= pend_next;
        count_reg <= count_next;
        entry_reg <= entry_next;
    end

endmodule

@@ design/page_table_map_translate.sv @@
// Top level of the page table map and translate unit.
// Depends on ptmt_pkg, ptmt_ctrl and ptmt_mem.
//
//   channel   direction  tvalid/tready  tuser          tdata
//   s_axis    in         yes            func[2:0]      virt, phys, end, count, flags
//   m_axis    out        yes            status[1:0]    phys_out, entry_out
//
// One item at a time. Translate and read entry pass the decode, memory read and
// result states before m_tvalid rises; out-of-range and rejected items skip the read.
// Map, map range and map region write their N pages in the run state, and identity
// fill writes all VIRT_PAGES pages: the single memory write port sets the page rate.
// The next item can be taken in the cycle after the result is registered.
// After reset a clearing pass writes the identity map with s_tready low. A stalled
// result sits in the output register while the next item is taken.
`timescale 1ns / 1ps

module page_table_map_translate #(
    parameter int VIRT_PAGES = ptmt_pkg::DEFAULT_VIRT_PAGES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // virt_addr[31:0], phys_addr[63:32], region_end[95:64], page_count[106:96],
    // page_flags[114:107], zero fill
    input  logic [ptmt_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [2:0]                       s_tuser,   // func
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // phys_out[31:0], entry_out[63:32]
    output logic [ptmt_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [1:0]                       m_tuser    // status
);
    import ptmt_pkg::*;

    mem_req_t    mem_req;
    logic [31:0] mem_rdata;
    logic        res_valid;
    logic        res_ready;
    result_t     res;

    logic        out_valid_reg;
    result_t     out_data_reg;

    ptmt_ctrl #(
        .VIRT_PAGES(VIRT_PAGES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_virt   (s_tdata[31:0]),
        .in_phys   (s_tdata[63:32]),
        .in_pend   (s_tdata[95:64]),
        .in_count  (s_tdata[106:96]),
        .in_flags  (s_tdata[114:107]),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    ptmt_mem #(
        .DEPTH(VIRT_PAGES)
    ) u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.status;
    assign m_tdata  = {out_data_reg.entry_out, out_data_reg.phys_out};

endmodule

@@ design/ptmt_check.sv @@
// Port-level checker for the page table map and translate unit, bound to the top.
// Depends on ptmt_pkg.
`timescale 1ns / 1ps

module ptmt_check (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [ptmt_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [1:0]                       m_tuser
);
    import ptmt_pkg::*;

    // one item in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous item in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STS_OK || m_tuser == STS_INVALID || m_tuser == STS_RANGE))
        else $error("undefined status code");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != STS_OK |-> m_tdata == '0)
        else $error("failed operation returned nonzero data");

endmodule

bind page_table_map_translate ptmt_check u_ptmt_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser)
);
